// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: operation and status codes,
// controller states and the command/flag structs between controller and datapath.
// No dependencies.
package spq_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;
    logic    do_insert;
    logic    do_remove;
    logic    do_clear;
    status_t status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_flags_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: stream ports, controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Bounded min-priority queue of DEPTH entries kept sorted by signed key in a
// shift-register cell chain; slot 0 is the head. Each input beat carries a
// mode in in_tuser (insert, remove least, clear, query head) and an entry in
// in_tdata; each one gives exactly one result beat. An insert goes after all
// held entries of equal or smaller key, so ties leave in arrival order; an
// insert into a full queue is dropped with status full, a remove from an
// empty queue returns status empty and a zero tag. Every result reports the
// removed tag, the head entry and the occupancy after the step (head fields
// are zero when the queue is empty). Rate: one item per clock cycle while the
// receiver takes results; the result is registered in the cycle after acceptance.
// All cells compare the new key in parallel and shift in the same cycle; the output
// register lets a new beat enter in the cycle the waiting result is taken.
module sorted_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  parameter int KEY_BITS = 32,
  localparam int CNT_W          = $clog2(DEPTH + 1),
  localparam int IN_FIELD_BITS  = TAG_BITS + KEY_BITS,
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8,
  localparam int OUT_FIELD_BITS = 2 * TAG_BITS + KEY_BITS + CNT_W + 1,
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // in_tdata, lowest bit up: payload_tag, priority_key, zero pad to bytes
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  // in_tuser: mode
  input  logic [1:0]              in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // out_tdata, lowest bit up: removed_tag, head_tag, head_key, occupancy,
  // is_empty, zero pad to bytes
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // out_tuser: status
  output logic [1:0]              out_tuser
);

  localparam int OCC_LSB       = 2 * TAG_BITS + KEY_BITS;
  localparam int HKEY_LSB      = 2 * TAG_BITS;
  localparam int EMPTY_BIT     = OCC_LSB + CNT_W;

  spq_pkg::dp_cmd_t           cmd;
  spq_pkg::dp_flags_t         flags;
  logic [TAG_BITS-1:0]        in_tag;
  logic signed [KEY_BITS-1:0] in_key;
  logic [TAG_BITS-1:0]        removed_tag;
  spq_pkg::status_t           status;
  logic [TAG_BITS-1:0]        head_tag;
  logic signed [KEY_BITS-1:0] head_key;
  logic [CNT_W-1:0]           occupancy;
  logic                       is_empty;

  // Unpack the entry fields of the input beat.
  assign in_tag = in_tdata[TAG_BITS-1:0];
  assign in_key = in_tdata[TAG_BITS +: KEY_BITS];

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .out_ready (out_tready),
    .flags     (flags),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_tag        (in_tag),
    .in_key        (in_key),
    .flags         (flags),
    .removed_tag_r (removed_tag),
    .status_r      (status),
    .head_tag_r    (head_tag),
    .head_key_r    (head_key),
    .occupancy_r   (occupancy),
    .is_empty_r    (is_empty)
  );

  // Pack the result beat; the size cast fills the byte pad with zeros.
  assign out_tdata = OUT_DATA_BITS'({is_empty, occupancy, head_key, head_tag, removed_tag});
  assign out_tuser = status;

  // Occupancy never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OCC_LSB +: CNT_W] <= CNT_W'(DEPTH)))
    else $error("occupancy above capacity");

  // The empty flag agrees with a zero occupancy, and an empty queue shows a zero head.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[EMPTY_BIT]) |->
      (out_tdata[OCC_LSB +: CNT_W] == '0) && (out_tdata[HKEY_LSB +: KEY_BITS] == '0)
      && (out_tdata[TAG_BITS +: TAG_BITS] == '0))
    else $error("empty result with nonzero head or occupancy");

  // A full status is only reported with the queue at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == spq_pkg::STATUS_FULL)) |->
      (out_tdata[OCC_LSB +: CNT_W] == CNT_W'(DEPTH)))
    else $error("full status below capacity");

  // Every accepted beat produces a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted beat without result");

endmodule

// ===== sv/spq_ctrl.sv =====
// Controller of the sorted priority queue: handshake FSM and operation decode.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  logic                out_ready,
  input  spq_pkg::dp_flags_t  flags,
  output logic                in_ready,
  output logic                out_valid,
  output spq_pkg::dp_cmd_t    cmd
);

  spq_pkg::state_t state_r, state_nxt;
  spq_pkg::mode_t  mode;
  logic            accept;

  assign mode     = spq_pkg::mode_t'(in_mode);
  assign in_ready = (state_r == spq_pkg::ST_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept) state_nxt = spq_pkg::ST_HOLD;
      end
      spq_pkg::ST_HOLD: begin
        if (out_ready && !accept) state_nxt = spq_pkg::ST_IDLE;
      end
      default: state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid     = (state_r == spq_pkg::ST_HOLD);
    cmd.load      = accept;
    cmd.do_insert = 1'b0;
    cmd.do_remove = 1'b0;
    cmd.do_clear  = 1'b0;
    cmd.status    = spq_pkg::STATUS_OK;
    unique case (mode)
      spq_pkg::MODE_INSERT: begin
        if (flags.full) cmd.status = spq_pkg::STATUS_FULL;
        else            cmd.do_insert = accept;
      end
      spq_pkg::MODE_REMOVE: begin
        if (flags.empty) cmd.status = spq_pkg::STATUS_EMPTY;
        else             cmd.do_remove = accept;
      end
      spq_pkg::MODE_CLEAR: begin
        cmd.do_clear = accept;
      end
      spq_pkg::MODE_QUERY: begin
        cmd.status = spq_pkg::STATUS_OK;
      end
      default: cmd.status = spq_pkg::STATUS_OK;
    endcase
  end

endmodule

// ===== sv/spq_datapath.sv =====
// Datapath of the sorted priority queue: shift-register cell chain and result register.
// Depends on spq_pkg.
module spq_datapath #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  parameter int KEY_BITS = 32,
  parameter int CNT_W    = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_pkg::dp_cmd_t           cmd,
  input  logic [TAG_BITS-1:0]        in_tag,
  input  logic signed [KEY_BITS-1:0] in_key,
  output spq_pkg::dp_flags_t         flags,
  output logic [TAG_BITS-1:0]        removed_tag_r,
  output spq_pkg::status_t           status_r,
  output logic [TAG_BITS-1:0]        head_tag_r,
  output logic signed [KEY_BITS-1:0] head_key_r,
  output logic [CNT_W-1:0]           occupancy_r,
  output logic                       is_empty_r
);

  logic signed [KEY_BITS-1:0] key_r [DEPTH];
  logic signed [KEY_BITS-1:0] key_nxt [DEPTH];
  logic signed [KEY_BITS-1:0] key_prev [DEPTH];
  logic signed [KEY_BITS-1:0] key_next [DEPTH];
  logic [TAG_BITS-1:0]        tag_r [DEPTH];
  logic [TAG_BITS-1:0]        tag_nxt [DEPTH];
  logic [TAG_BITS-1:0]        tag_prev [DEPTH];
  logic [TAG_BITS-1:0]        tag_next [DEPTH];
  logic [DEPTH-1:0]           le;
  logic [DEPTH-1:0]           prev_le;
  logic [CNT_W-1:0]           count_r, count_nxt;

  assign flags.full  = (count_r == CNT_W'(DEPTH));
  assign flags.empty = (count_r == '0);

  // Every held cell compares its key with the new one at once; the result is a
  // thermometer prefix because the chain is sorted.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (count_r > CNT_W'(i)) && (key_r[i] <= in_key);
    end
    prev_le[0]  = 1'b1;
    key_prev[0] = in_key;
    tag_prev[0] = in_tag;
    for (int i = 1; i < DEPTH; i++) begin
      prev_le[i]  = le[i-1];
      key_prev[i] = key_r[i-1];
      tag_prev[i] = tag_r[i-1];
    end
    key_next[DEPTH-1] = key_r[DEPTH-1];
    tag_next[DEPTH-1] = tag_r[DEPTH-1];
    for (int i = 0; i < DEPTH - 1; i++) begin
      key_next[i] = key_r[i+1];
      tag_next[i] = tag_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      key_nxt[i] = key_r[i];
      tag_nxt[i] = tag_r[i];
      if (cmd.do_insert && !le[i]) begin
        // first cell past the prefix takes the new entry, the rest shift up
        key_nxt[i] = prev_le[i] ? in_key : key_prev[i];
        tag_nxt[i] = prev_le[i] ? in_tag : tag_prev[i];
      end else if (cmd.do_remove) begin
        key_nxt[i] = key_next[i];
        tag_nxt[i] = tag_next[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    priority if (cmd.do_clear)  count_nxt = '0;
    else if (cmd.do_insert)     count_nxt = count_r + CNT_W'(1);
    else if (cmd.do_remove)     count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      key_r[i] <= key_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
  end

  // Result register: removed tag, status, and head and occupancy as they stand after the step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      removed_tag_r <= cmd.do_remove ? tag_r[0] : '0;
      status_r      <= cmd.status;
      head_tag_r    <= (count_nxt != '0) ? tag_nxt[0] : '0;
      head_key_r    <= (count_nxt != '0) ? key_nxt[0] : '0;
      occupancy_r   <= count_nxt;
      is_empty_r    <= (count_nxt == '0);
    end
  end

endmodule

// ===== tb/sv/tb_sorted_priority_queue.sv =====
// Self-checking testbench for sorted_priority_queue: directed and random beats with a
// shadow sorted queue that predicts every result beat. Depends on spq_pkg and the RTL.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int IN_W        = 48;      // payload_tag + priority_key
  localparam int OUT_W       = 72;      // 70 field bits padded to bytes
  localparam int CYCLE_LIMIT = 200000;  // many times the slowest legal run
  localparam int MAX_GAP     = 12;

  // Expected contents of one result beat.
  typedef struct packed {
    logic [15:0]        removed_tag;
    status_t            status;
    logic [15:0]        head_tag;
    logic signed [31:0] head_key;
    logic [4:0]         occupancy;
    logic               is_empty;
  } queue_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  // in_tdata, lowest bit up: payload_tag, priority_key
  logic [IN_W-1:0]  in_tdata   = '0;
  // in_tuser: mode
  logic [1:0]       in_tuser   = MODE_QUERY;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // out_tdata, lowest bit up: removed_tag, head_tag, head_key, occupancy, is_empty, pad
  logic [OUT_W-1:0] out_tdata;
  // out_tuser: status
  logic [1:0]       out_tuser;

  // Shadow of the sorted store; slot 0 is the head.
  logic signed [31:0] shadow_keys [DEPTH];
  logic [15:0]        shadow_tags [DEPTH];
  int                 shadow_count = 0;

  queue_result_t pending_results [$];

  // Idle control shared by the test tasks and the two stream sides.
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  int hold_request = 0;
  int hold_left    = 0;
  int rx_wait      = 0;

  int cycle_count  = 0;
  int err_count    = 0;
  int beats_sent   = 0;
  int beats_seen   = 0;
  int full_drops   = 0;
  int empty_pops   = 0;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Apply one operation to the shadow queue and return the result beat it must cause.
  function automatic queue_result_t apply_queue_op(mode_t op, logic [15:0] tag,
                                                   logic signed [31:0] key);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          // Go past every entry with an equal or smaller key so ties stay FIFO.
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_tags[i] = shadow_tags[i-1];
          end
          shadow_keys[pos] = key;
          shadow_tags[pos] = tag;
          shadow_count++;
        end
      end
      MODE_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.removed_tag = shadow_tags[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_tags[i-1] = shadow_tags[i];
          end
          shadow_count--;
        end
      end
      MODE_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (shadow_count > 0) begin
      r.head_tag = shadow_tags[0];
      r.head_key = shadow_keys[0];
    end
    r.occupancy = 5'(shadow_count);
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one beat, hold it until accepted, then record what it must produce.
  // Called and returns at a rising edge; the beat is accepted at the return edge.
  task automatic send_op(mode_t op, logic [15:0] tag, logic signed [31:0] key);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {key, tag};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_queue_op(op, tag, key));
    beats_sent++;
  endtask

  // Mix of tie-prone small keys, range extremes and fully random keys.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $signed(32'($urandom_range(0, 4))) - 32'sd2;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  // Weighted mode draw: insert_pct sets how fast the queue fills.
  function automatic mode_t pick_mode(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return MODE_INSERT;
    if (r < 94) return MODE_REMOVE;
    if (r < 97) return MODE_QUERY;
    return MODE_CLEAR;
  endfunction

  // Remove and query on an empty queue right after reset.
  task automatic test_empty_queue();
    send_op(MODE_REMOVE, 16'hFFFF, 32'sh7FFF_FFFF);
    send_op(MODE_QUERY, 16'h0000, 32'sh8000_0000);
  endtask

  // Key extremes, a tie on equal keys and removal in key order.
  task automatic test_sort_order();
    send_op(MODE_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    send_op(MODE_INSERT, 16'h0000, 32'sh8000_0000);
    send_op(MODE_INSERT, 16'h0001, 32'sd0);
    send_op(MODE_INSERT, 16'h0002, 32'sd0);
    send_op(MODE_INSERT, 16'hA5A5, -32'sd1);
    send_op(MODE_INSERT, 16'h5A5A, 32'sh0001_0000);
    send_op(MODE_QUERY, 16'h1234, 32'sh1234_5678);
    send_op(MODE_REMOVE, 16'h0000, 32'sd0);
    send_op(MODE_REMOVE, 16'h0000, 32'sd0);
  endtask

  // Fill to DEPTH, drop an insert on a full queue, then clear.
  task automatic test_full_and_clear();
    while (shadow_count < DEPTH) send_op(MODE_INSERT, 16'($urandom), pick_key());
    send_op(MODE_INSERT, 16'hBEEF, 32'sh8000_0000);
    send_op(MODE_QUERY, 16'h0000, 32'sd0);
    send_op(MODE_CLEAR, 16'hFFFF, 32'shFFFF_FFFF);
    send_op(MODE_REMOVE, 16'h0000, 32'sd0);
  endtask

  // Long random run; the insert bias changes every chunk so occupancy swings
  // between empty and full.
  task automatic test_random_traffic(int n_items);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      send_op(pick_mode(insert_pct), 16'($urandom), pick_key());
    end
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_burst(int n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while beats keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    hold_request = 80;
    for (int i = 0; i < 24; i++) send_op(pick_mode(60), 16'($urandom), pick_key());
    tx_idle_en   = 1'b1;
  endtask

  // Receiver: per-beat random stall, plus a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_wait = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      out_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= (rx_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Checker: compare each taken result beat with the oldest expectation; also
  // guard the run against a hang.
  always @(posedge clk) begin
    queue_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb_sorted_priority_queue: FAIL");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (want.status == STATUS_FULL)  full_drops++;
        if (want.status == STATUS_EMPTY) empty_pops++;
        check_field("removed_tag", 32'(out_tdata[15:0]),  32'(want.removed_tag));
        check_field("status",      32'(out_tuser),        32'(want.status));
        check_field("head_tag",    32'(out_tdata[31:16]), 32'(want.head_tag));
        check_field("head_key",    out_tdata[63:32],      want.head_key);
        check_field("occupancy",   32'(out_tdata[68:64]), 32'(want.occupancy));
        check_field("is_empty",    32'(out_tdata[69]),    32'(want.is_empty));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_sort_order();
    test_full_and_clear();
    test_random_traffic(480);
    test_backpressure();
    test_burst(80);

    // Drop valid, drain the remaining results, then let the pipeline settle.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run covered %0d operation beats and %0d result beats", beats_sent, beats_seen);
    $display("including %0d dropped full inserts and %0d removes from an empty queue",
             full_drops, empty_pops);
    if (err_count == 0) begin
      $display("tb_sorted_priority_queue: PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_sorted_priority_queue: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
